FILE: design/hrat_pkg.sv
// shared types, constants and lookup functions for the hall rotor angle tracker
`timescale 1ns / 1ps

package hrat_pkg;

  localparam int unsigned ANGLE_W  = 16;
  localparam int unsigned PERIOD_W = 15;
  localparam int unsigned HALL_W   = 3;

  localparam logic [ANGLE_W-1:0]  SECTOR_ANGLE_RST = 16'd10923;
  localparam logic [PERIOD_W-1:0] PERIOD_RST       = 15'd1600;
  localparam logic [ANGLE_W-1:0]  PERIOD_MIN_EXCL  = 16'd50;
  localparam logic [ANGLE_W-1:0]  PERIOD_MAX_EXCL  = 16'd32000;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_HALL = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [HALL_W-1:0] hall;
  } in_word_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]  cur_angle;
    logic [ANGLE_W-1:0]  angle_step;
    logic [PERIOD_W-1:0] period_average;
    logic                hall_invalid;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic tick_mul;
    logic tick_add;
    logic hall_upd;
    logic div_step;
    logic out_load;
  } hrat_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic new_is_hall;
    logic new_hall_ok;
    logic div_last;
    logic out_free;
  } hrat_stat_t;

  function automatic logic hall_code_ok(input logic [HALL_W-1:0] code);
    hall_code_ok = (code != 3'd0) && (code != 3'd7);
  endfunction

  function automatic logic [ANGLE_W-1:0] hall_sector_angle(input logic [HALL_W-1:0] code);
    case (code)
      3'd4:    hall_sector_angle = 16'd0;
      3'd5:    hall_sector_angle = 16'd10923;
      3'd1:    hall_sector_angle = 16'd21845;
      3'd3:    hall_sector_angle = 16'd32768;
      3'd2:    hall_sector_angle = 16'd43691;
      3'd6:    hall_sector_angle = 16'd54613;
      default: hall_sector_angle = 16'd0;
    endcase
  endfunction

endpackage

FILE: design/hrat_dp.sv
// datapath: angle state, tick multiply, period filter, serial step divider, output register
`timescale 1ns / 1ps

module hrat_dp
  import hrat_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  in_word_t            in_data,
  input  logic                cfg_valid,
  input  logic [ANGLE_W-1:0]  cfg_data,
  input  hrat_cmd_t           cmd,
  output hrat_stat_t          stat,
  output logic                out_valid,
  input  logic                out_stall,
  output out_word_t           out_data
);

  logic [ANGLE_W-1:0]  sector_angle_r;
  logic [ANGLE_W-1:0]  angle_r;
  logic [ANGLE_W-1:0]  step_r;
  logic [ANGLE_W-1:0]  base_r;
  logic [ANGLE_W-1:0]  ticks_r;
  logic [PERIOD_W-1:0] period_r;
  logic                out_valid_r;
  logic [3:0]          div_cnt_r;

  in_word_t            req_r;
  logic [ANGLE_W-1:0]  prod_r;
  logic [PERIOD_W-1:0] rem_r;
  logic [ANGLE_W-1:0]  quo_r;
  out_word_t           out_data_r;

  logic [ANGLE_W-1:0]   ticks_inc;
  logic [2*ANGLE_W-1:0] prod_full;
  logic                 period_upd;
  logic [17:0]          period_sum;
  logic [PERIOD_W-1:0]  period_nxt;
  logic [ANGLE_W-1:0]   trial;
  logic                 trial_ge;
  logic [ANGLE_W-1:0]   trial_diff;
  logic [ANGLE_W-1:0]   sector_base;

  assign ticks_inc  = ticks_r + 16'd1;
  assign prod_full  = ticks_inc * step_r;

  // filter only when the measured interval looks plausible
  assign period_upd = (ticks_r > PERIOD_MIN_EXCL) && (ticks_r < PERIOD_MAX_EXCL);
  assign period_sum = {1'b0, period_r, 2'b00} - {3'b000, period_r} + {2'b00, ticks_r};
  assign period_nxt = period_upd ? period_sum[16:2] : period_r;

  assign sector_base = hall_sector_angle(req_r.hall);

  // restoring division, one quotient bit a cycle; a zero divisor gives all ones
  assign trial      = {rem_r, quo_r[ANGLE_W-1]};
  assign trial_ge   = trial >= {1'b0, period_r};
  assign trial_diff = trial - {1'b0, period_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_angle_r <= SECTOR_ANGLE_RST;
      angle_r        <= '0;
      step_r         <= '0;
      base_r         <= '0;
      ticks_r        <= '0;
      period_r       <= PERIOD_RST;
      out_valid_r    <= 1'b0;
      div_cnt_r      <= '0;
    end else begin
      if (cfg_valid) begin
        sector_angle_r <= cfg_data;
      end
      if (cmd.tick_mul) begin
        ticks_r <= ticks_inc;
      end
      if (cmd.tick_add) begin
        angle_r <= base_r + prod_r;
      end
      if (cmd.hall_upd) begin
        period_r  <= period_nxt;
        ticks_r   <= '0;
        base_r    <= sector_base;
        angle_r   <= sector_base;
        div_cnt_r <= '0;
      end
      if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + 4'd1;
        if (stat.div_last) begin
          step_r <= {quo_r[ANGLE_W-2:0], trial_ge};
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_data;
    end
    if (cmd.tick_mul) begin
      prod_r <= prod_full[ANGLE_W-1:0];
    end
    if (cmd.hall_upd) begin
      rem_r <= '0;
      quo_r <= sector_angle_r;
    end
    if (cmd.div_step) begin
      rem_r <= trial_ge ? trial_diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
      quo_r <= {quo_r[ANGLE_W-2:0], trial_ge};
    end
    if (cmd.out_load) begin
      out_data_r.cur_angle      <= angle_r;
      out_data_r.angle_step     <= step_r;
      out_data_r.period_average <= period_r;
      out_data_r.hall_invalid   <= (req_r.req_type == REQ_HALL) && !hall_code_ok(req_r.hall);
    end
  end

  assign stat.new_is_hall = (in_data.req_type == REQ_HALL);
  assign stat.new_hall_ok = hall_code_ok(in_data.hall);
  assign stat.div_last    = (div_cnt_r == 4'd15);
  assign stat.out_free    = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/hrat_ctrl.sv
// controller: sequences tick, hall update, division steps and output load
`timescale 1ns / 1ps

module hrat_ctrl
  import hrat_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  hrat_stat_t stat,
  output hrat_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_PER  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.load_req = accept;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!stat.new_is_hall) begin
            state_nxt = S_MUL;
          end else if (stat.new_hall_ok) begin
            state_nxt = S_PER;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_MUL: begin
        cmd.tick_mul = 1'b1;
        state_nxt    = S_ADD;
      end
      S_ADD: begin
        cmd.tick_add = 1'b1;
        state_nxt    = S_OUT;
      end
      S_PER: begin
        cmd.hall_upd = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/hall_rotor_angle_tracker.sv
// top level of the hall sensor rotor angle tracker
//
//   channel   direction   handshake          word
//   in_       input       in_valid/in_stall  in_word_t  {req_type, hall}
//   out_      output      out_valid/out_stall out_word_t {cur_angle, angle_step,
//                                                          period_average, hall_invalid}
//   cfg_      input       cfg_valid/cfg_ready sector_angle, 16 bits
//
// one word at a time: a tick passes accept, multiply, add and output load, an invalid
// hall code goes from accept to output load, and a valid hall change passes accept,
// period update, 16 serial restoring divider steps forming the step per tick, output load
// the output register decouples the sides: a new word is taken while a result waits,
// and the sequence holds in its last state until the output register is free
// synchronous active-low reset restores sector angle 10923, period 1600, angle state and out_valid zero
`timescale 1ns / 1ps

module hall_rotor_angle_tracker
  import hrat_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_word_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_word_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [ANGLE_W-1:0] cfg_data
);

  hrat_cmd_t  cmd;
  hrat_stat_t stat;

  // register writes are to land only while idle; the block does not enforce it, the port is always open
  assign cfg_ready = 1'b1;

  // sequencer for ticks, hall updates and the divider
  hrat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // angle state, period filter, divider and output register
  hrat_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
